@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the button latch core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold whenever the antecedent holds.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// The condition must never be true.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");

`endif

@@ rtl/core/btnlat_pkg.sv @@
// ----------------------------------------------------------------------------
// btnlat_pkg
// Types, codes and sizes shared by the button latch controller and datapath.
// ----------------------------------------------------------------------------
package btnlat_pkg;

  // Number of pad buttons and the index width into the per-button records.
  localparam int unsigned NumButtons = 12;
  localparam int unsigned BtnIdxW    = (NumButtons > 1) ? $clog2(NumButtons) : 1;

  // Field widths.
  localparam int unsigned FuncW   = 3;
  localparam int unsigned ButtonW = 4;
  localparam int unsigned EvTypeW = 16;
  localparam int unsigned EvValW  = 2;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 1;

  // Among events, only key events touch the pressed bit.
  localparam logic [EvTypeW-1:0] EvTypeKey = 16'd1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgRepeatDelay    = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgRepeatInterval = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [CfgW-1:0] RepeatDelayRst    = 16'd350;
  localparam logic [CfgW-1:0] RepeatIntervalRst = 16'd90;

  // Operation codes.
  typedef enum logic [FuncW-1:0] {
    FUNC_EVENT     = 3'd0,
    FUNC_PEEK      = 3'd1,
    FUNC_READ_CLR  = 3'd2,
    FUNC_REPEAT    = 3'd3,
    FUNC_HELD      = 3'd4,
    FUNC_CLEAR_ALL = 3'd5
  } func_e;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // load the accepted item into the operand registers
    logic exec;     // apply the operation and load the result register
  } cmd_t;

endpackage

@@ rtl/core/btnlat_ctrl.sv @@
// ----------------------------------------------------------------------------
// btnlat_ctrl
// Sequencer for the button latch: takes one item, executes it, and owns the
// result valid flag of the output register.
// ----------------------------------------------------------------------------
module btnlat_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output btnlat_pkg::cmd_t  cmd_o
);
  import btnlat_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   res_free;

  // The result register can be loaded when empty or being drained now.
  assign res_free = !out_valid_q || !out_stall_i;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (res_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output and command logic.
  always_comb begin
    in_stall_o    = 1'b1;
    cmd_o.capture = 1'b0;
    cmd_o.exec    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.exec = res_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Result valid flag: set on execution, cleared on an output transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/core/btnlat_dp.sv @@
// ----------------------------------------------------------------------------
// btnlat_dp
// Datapath for the button latch: operand registers, per-button pressed and
// timing records, configuration registers and the result register.
// ----------------------------------------------------------------------------
module btnlat_dp (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  btnlat_pkg::cmd_t                        cmd_i,
  input  logic [btnlat_pkg::FuncW-1:0]            func_i,
  input  logic [btnlat_pkg::ButtonW-1:0]          button_i,
  input  logic [btnlat_pkg::EvTypeW-1:0]          event_type_i,
  input  logic [btnlat_pkg::EvValW-1:0]           event_value_i,
  input  logic [btnlat_pkg::TimeW-1:0]            now_ms_i,
  input  logic                                    cfg_we_i,
  input  logic [btnlat_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [btnlat_pkg::CfgW-1:0]             cfg_data_i,
  output logic                                    status_o,
  output logic [btnlat_pkg::TimeW-1:0]            held_ms_o
);
  import btnlat_pkg::*;

  // Operand registers.
  logic [FuncW-1:0]   func_q;
  logic [ButtonW-1:0] button_q;
  logic [EvTypeW-1:0] etype_q;
  logic [EvValW-1:0]  evalue_q;
  logic [TimeW-1:0]   now_q;

  // Configuration registers.
  logic [CfgW-1:0] delay_q;
  logic [CfgW-1:0] interval_q;

  // Per-button records.
  logic [NumButtons-1:0] pressed_q, pressed_d;
  logic [NumButtons-1:0] rpt_armed_q, rpt_armed_d;
  logic [NumButtons-1:0] hold_armed_q, hold_armed_d;
  logic [TimeW-1:0]      rpt_start_q [NumButtons];
  logic [TimeW-1:0]      rpt_last_q  [NumButtons];
  logic [TimeW-1:0]      hold_start_q [NumButtons];

  // Result register.
  logic             status_q, status_d;
  logic [TimeW-1:0] held_q, held_d;

  logic               btn_ok;
  logic [BtnIdxW-1:0] btn_idx;
  logic               sel_pressed;
  logic [TimeW-1:0]   rpt_age;
  logic [TimeW-1:0]   rpt_gap;
  logic [TimeW-1:0]   hold_age;
  logic               rpt_due;
  logic               rpt_start_we;
  logic               rpt_last_we;
  logic               hold_start_we;

  // Capture the accepted item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q   <= func_i;
      button_q <= button_i;
      etype_q  <= event_type_i;
      evalue_q <= event_value_i;
      now_q    <= now_ms_i;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q    <= RepeatDelayRst;
      interval_q <= RepeatIntervalRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgRepeatDelay:    delay_q    <= cfg_data_i;
        CfgRepeatInterval: interval_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Selected button and its elapsed times.
  assign btn_ok      = ({1'b0, button_q} < (ButtonW + 1)'(NumButtons));
  assign btn_idx     = button_q[BtnIdxW-1:0];
  assign sel_pressed = pressed_q[btn_idx];
  assign rpt_age     = now_q - rpt_start_q[btn_idx];
  assign rpt_gap     = now_q - rpt_last_q[btn_idx];
  assign hold_age    = now_q - hold_start_q[btn_idx];
  assign rpt_due     = (rpt_age >= {{(TimeW-CfgW){1'b0}}, delay_q}) &&
                       (rpt_gap >= {{(TimeW-CfgW){1'b0}}, interval_q});

  // Operation decode and record update.
  always_comb begin
    pressed_d     = pressed_q;
    rpt_armed_d   = rpt_armed_q;
    hold_armed_d  = hold_armed_q;
    rpt_start_we  = 1'b0;
    rpt_last_we   = 1'b0;
    hold_start_we = 1'b0;
    status_d      = 1'b0;
    held_d        = '0;
    if (cmd_i.exec) begin
      if (func_q == FUNC_CLEAR_ALL) begin
        pressed_d = '0;
      end else if (btn_ok) begin
        unique case (func_q)
          FUNC_EVENT: begin
            if (etype_q == EvTypeKey) begin
              pressed_d[btn_idx] = |evalue_q;
            end
          end
          FUNC_PEEK: begin
            status_d = sel_pressed;
          end
          FUNC_READ_CLR: begin
            status_d           = sel_pressed;
            pressed_d[btn_idx] = 1'b0;
          end
          FUNC_REPEAT: begin
            if (!sel_pressed) begin
              rpt_armed_d[btn_idx] = 1'b0;
            end else if (!rpt_armed_q[btn_idx]) begin
              rpt_armed_d[btn_idx] = 1'b1;
              rpt_start_we         = 1'b1;
              rpt_last_we          = 1'b1;
              status_d             = 1'b1;
            end else if (rpt_due) begin
              rpt_last_we = 1'b1;
              status_d    = 1'b1;
            end
          end
          FUNC_HELD: begin
            if (!sel_pressed) begin
              hold_armed_d[btn_idx] = 1'b0;
            end else if (!hold_armed_q[btn_idx]) begin
              // First query while pressed starts the clock at zero.
              hold_armed_d[btn_idx] = 1'b1;
              hold_start_we         = 1'b1;
            end else begin
              held_d = hold_age;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Pressed and armed flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q    <= '0;
      rpt_armed_q  <= '0;
      hold_armed_q <= '0;
    end else begin
      pressed_q    <= pressed_d;
      rpt_armed_q  <= rpt_armed_d;
      hold_armed_q <= hold_armed_d;
    end
  end

  // Timestamps; each is written before its armed flag lets it be read.
  always_ff @(posedge clk_i) begin
    if (rpt_start_we) begin
      rpt_start_q[btn_idx] <= now_q;
    end
    if (rpt_last_we) begin
      rpt_last_q[btn_idx] <= now_q;
    end
    if (hold_start_we) begin
      hold_start_q[btn_idx] <= now_q;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      held_q   <= held_d;
    end
  end

  assign status_o  = status_q;
  assign held_ms_o = held_q;

endmodule

@@ rtl/core/button_latch_with_autorepeat_core.sv @@
// Flow: an item transferred in is loaded into the operand registers and then executed in the
// EXEC state; its result is valid from then on, or later while an earlier result is still stalled.
// The block takes no new item until the current one is executed: it captures the item, then runs
// the read-modify-write of the button record, and waits longer while the result is stalled.
// Reset: asynchronous, active low; clears pressed and armed flags and the
// result valid flag, and loads repeat delay 350 ms and interval 90 ms.
// ----------------------------------------------------------------------------
// button_latch_with_autorepeat_core
// Pad button latch with typematic auto-repeat and hold timing for twelve
// buttons, built as a controller and a datapath.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module button_latch_with_autorepeat_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [btnlat_pkg::FuncW-1:0]       func_i,
  input  logic [btnlat_pkg::ButtonW-1:0]     button_i,
  input  logic [btnlat_pkg::EvTypeW-1:0]     event_type_i,
  input  logic [btnlat_pkg::EvValW-1:0]      event_value_i,
  input  logic [btnlat_pkg::TimeW-1:0]       now_ms_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               status_o,
  output logic [btnlat_pkg::TimeW-1:0]       held_ms_o,
  input  logic                               cfg_we_i,
  input  logic [btnlat_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [btnlat_pkg::CfgW-1:0]        cfg_data_i
);
  import btnlat_pkg::*;

  cmd_t cmd;

  // Sequencer.
  btnlat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Records, configuration and result.
  btnlat_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .func_i        (func_i),
    .button_i      (button_i),
    .event_type_i  (event_type_i),
    .event_value_i (event_value_i),
    .now_ms_i      (now_ms_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .status_o      (status_o),
    .held_ms_o     (held_ms_o)
  );

  // An item is never captured and executed in the same cycle.
  `ASSERT_NEVER(a_no_capture_exec, clk_i, rst_ni, cmd.capture && cmd.exec)
  // Execution always leaves a pending result.
  `ASSERT_NEXT(a_exec_gives_result, clk_i, rst_ni, cmd.exec, out_valid_o)
  // After an input transfer the block is busy with that item.
  `ASSERT_NEXT(a_busy_after_transfer, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  // Execution only loads the result register when it is free.
  `ASSERT_IMPL(a_exec_res_free, clk_i, rst_ni, cmd.exec, !(out_valid_o && out_stall_i))

endmodule
